/* design/positional_insert_delete_array_macros.svh */
// Assertion macros used by the checker file of the positional insert/delete array.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PIDA_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle forces the consequent in the next cycle.
`define PIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pida_pkg.sv */
// Package with the types, constants and helper functions of the positional insert/delete array.
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

    localparam int CAPACITY = 8;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (LEN_W > 4) ? LEN_W : 4;
    localparam int RESET_N  = (CAPACITY < 5) ? CAPACITY : 5;

    localparam logic [2:0] OP_SET_LEN   = 3'd0;
    localparam logic [2:0] OP_DUMP      = 3'd1;
    localparam logic [2:0] OP_INSERT    = 3'd2;
    localparam logic [2:0] OP_OVERWRITE = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         position;
        logic signed [31:0] value;
        logic [3:0]         new_length;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         entry_index;
        logic signed [31:0] entry_value;
        logic               is_empty;
        logic               last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             exec;
        logic             dump_load;
        logic [IDX_W-1:0] dump_idx;
        logic             dump_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             out_free;
        logic [LEN_W-1:0] length;
    } stat_t;

    // Word held by an entry after reset.
    function automatic logic signed [31:0] reset_word(input int idx);
        logic signed [31:0] w;
        w = '0;
        if (idx < RESET_N)
        begin
            w = 32'(idx + 1);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/positional_insert_delete_array.sv */
// Top level of the positional insert/delete array: controller and datapath.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------------------
//  req     | in        | req_valid / req_stall  | operation, position, value, new_length
//  rsp     | out       | rsp_valid / rsp_stall  | status, entry_index, entry_value,
//          |           |                        | is_empty, last
//
// An edit request (set length, insert, overwrite, delete, unknown code, or a dump
// of an empty array) is accepted and its single result appears in the result
// register at the next edge. For a dump of n entries the request is accepted,
// then the dump sequencer in the controller loads one entry per cycle into the
// result register whenever the result register is free.
// Reset loads the words 1 to 5 and a length of five; no clearing pass follows.
// A stalled result holds the result register and with it the whole block.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  pida_pkg::req_t     req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pida_pkg::rsp_t     rsp
);
    import pida_pkg::*;

    // Commands tell the datapath when to apply an edit and which entry to dump;
    // status tells the controller whether the result register can take a new
    // result and how many entries are live.
    cmd_t  cmd;
    stat_t stat;

    pida_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req.operation),
        .req_stall     (req_stall),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds every entry in its own cell, so an insert or delete
    // shifts the whole tail in the cycle the request is accepted.
    pida_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

/* design/pida_ctrl.sv */
// Controller state machine: request acceptance and dump sequencing.
`timescale 1ns / 1ps
`default_nettype none

module pida_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic [2:0]    req_operation,
    output logic               req_stall,
    input  pida_pkg::stat_t    stat,
    output pida_pkg::cmd_t     cmd
);
    import pida_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             last_entry;

    assign req_stall  = !((state_reg == S_IDLE) && stat.out_free);
    assign accept     = req_valid && !req_stall;
    assign last_entry = (LEN_W'(idx_reg) + LEN_W'(1)) == stat.length;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.exec      = 1'b0;
        cmd.dump_load = 1'b0;
        cmd.dump_idx  = idx_reg;
        cmd.dump_last = last_entry;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_operation == OP_DUMP) && (stat.length != '0))
                    begin
                        state_next = S_DUMP;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_load = 1'b1;
                    if (last_entry)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* design/pida_dpath.sv */
// Datapath: entry shift cells, length register and result register.
`timescale 1ns / 1ps
`default_nettype none

module pida_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  pida_pkg::req_t     req,
    input  wire logic          rsp_stall,
    output logic               rsp_valid,
    output pida_pkg::rsp_t     rsp,
    input  pida_pkg::cmd_t     cmd,
    output pida_pkg::stat_t    stat
);
    import pida_pkg::*;

    logic signed [31:0] entries_reg [CAPACITY];
    logic signed [31:0] entries_next [CAPACITY];
    logic [LEN_W-1:0]   length_reg, length_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;
    logic [CMP_W-1:0]   pos_x, len_x;
    logic [1:0]         status;

    assign pos_x = CMP_W'(req.position);
    assign len_x = CMP_W'(length_reg);

    assign stat.out_free = !out_valid_reg || !rsp_stall;
    assign stat.length   = length_reg;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        length_next = length_reg;
        status      = ST_OK;
        unique case (req.operation)
            OP_SET_LEN:
            begin
                if (CMP_W'(req.new_length) > CMP_W'(CAPACITY))
                begin
                    status = ST_BAD;
                end
                else
                begin
                    length_next = LEN_W'(req.new_length);
                end
            end
            OP_DUMP:
            begin
                status = ST_OK;
            end
            OP_INSERT:
            begin
                if (len_x >= CMP_W'(CAPACITY))
                begin
                    status = ST_FULL;
                end
                else if (pos_x > len_x)
                begin
                    status = ST_BAD;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CMP_W'(i) == pos_x)
                        begin
                            entries_next[i] = req.value;
                        end
                        else if ((i > 0) && (CMP_W'(i) > pos_x) && (CMP_W'(i) <= len_x))
                        begin
                            entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    length_next = length_reg + LEN_W'(1);
                end
            end
            OP_OVERWRITE:
            begin
                if (pos_x >= len_x)
                begin
                    status = ST_BAD;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CMP_W'(i) == pos_x)
                        begin
                            entries_next[i] = req.value;
                        end
                    end
                end
            end
            OP_DELETE:
            begin
                if (pos_x >= len_x)
                begin
                    status = ST_BAD;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if ((CMP_W'(i) >= pos_x) && (CMP_W'(i + 1) < len_x))
                        begin
                            entries_next[i] = entries_reg[i + 1];
                        end
                    end
                    length_next = length_reg - LEN_W'(1);
                end
            end
            default:
            begin
                status = ST_BAD;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (cmd.exec)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = status;
            out_next.entry_index = '0;
            out_next.entry_value = '0;
            out_next.is_empty    = (req.operation == OP_DUMP);
            out_next.last        = 1'b1;
        end
        else if (cmd.dump_load)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = ST_OK;
            out_next.entry_index = 3'(cmd.dump_idx);
            out_next.entry_value = entries_reg[cmd.dump_idx];
            out_next.is_empty    = 1'b0;
            out_next.last        = cmd.dump_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= reset_word(i);
            end
            length_reg    <= LEN_W'(RESET_N);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    entries_reg[i] <= entries_next[i];
                end
                length_reg <= length_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

/* design/pida_checker.sv */
// Port-level checker for the positional insert/delete array and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_insert_delete_array_macros.svh"

module pida_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_stall,
    input wire logic       rsp_valid,
    input wire logic       rsp_stall,
    input pida_pkg::rsp_t  rsp
);
    import pida_pkg::*;

    logic rsp_waiting;
    logic err_ok;
    logic empty_ok;
    logic mid_ok;
    logic dump_waiting;

    // A result waiting on the receiver, and a dump entry that is not the final one waiting on it.
    assign rsp_waiting  = rsp_valid && rsp_stall;
    assign dump_waiting = rsp_valid && !rsp.last && rsp_stall;

    assign err_ok   = !rsp_valid || (rsp.status == ST_OK) || rsp.last;
    assign empty_ok = !rsp_valid || !rsp.is_empty
                      || (rsp.last && (rsp.entry_value == 0) && (rsp.status == ST_OK));
    assign mid_ok   = !rsp_valid || rsp.last || (!rsp.is_empty && (rsp.status == ST_OK));

    `PIDA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_waiting, rsp_valid, "stalled result dropped")
    `PIDA_ASSERT_ALWAYS(a_err_last, clk, rst_n, err_ok, "error status without last")
    `PIDA_ASSERT_ALWAYS(a_empty, clk, rst_n, empty_ok, "malformed empty dump")
    `PIDA_ASSERT_ALWAYS(a_mid_dump, clk, rst_n, mid_ok, "non-final result outside a dump")
    `PIDA_ASSERT_NEXT(a_busy, clk, rst_n, dump_waiting, req_stall, "request taken during a dump")

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (.*);

`default_nettype wire
